// ===== hdl/fcfs_pkg.sv =====
// Shared types, constants and lookup functions for the firing sequencer.
package fcfs_pkg;

    localparam int CHANNELS = 15;

    localparam logic [7:0] FIRE_TIME_RST = 8'd50;
    localparam logic [3:0] STEP_RST      = 4'd1;
    localparam logic [3:0] SEL_MANUAL    = 4'd8;
    localparam logic [3:0] SEL_FIRST     = 4'd1;
    localparam logic [3:0] CH_LAST_STEP  = 4'd14;
    localparam logic [3:0] CH_TOP        = 4'd15;
    localparam logic [3:0] CH_FIRST      = 4'd1;

    localparam int PADDR_W = 3;

    // Register index, taken from paddr[2]
    localparam logic REG_FIRE_TIME = 1'b0;
    localparam logic REG_TEST_MODE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_FIRE = 2'd1,
        PH_GAP  = 2'd2
    } t_phase;

    typedef struct packed {
        logic       command;
        logic [2:0] mode_pins;
    } t_in_word;

    typedef struct packed {
        logic [14:0] channel_drive;
        logic        busy_res;
        logic        sequence_done;
    } t_out_word;

    // Channel number 1..15 to its drive bit; zero and channels above CHANNELS drive nothing
    function automatic logic [14:0] one_hot(input logic [3:0] ch);
        logic [15:0] mask;
        logic [14:0] res;
        mask = (16'(1) << CHANNELS) - 16'(1);
        if (ch == 4'd0) begin
            res = '0;
        end else begin
            res = (15'(1) << (ch - 4'd1)) & mask[14:0];
        end
        return res;
    endfunction

    // Switch levels to mode selection (1..7 periods, 8 manual)
    function automatic logic [3:0] pins_to_sel(input logic [2:0] pins);
        logic [3:0] sel;
        case (pins)
            3'b000:  sel = 4'd1;
            3'b001:  sel = 4'd3;
            3'b010:  sel = 4'd6;
            3'b011:  sel = 4'd2;
            3'b100:  sel = 4'd5;
            3'b101:  sel = 4'd7;
            3'b110:  sel = 4'd4;
            default: sel = 4'd8;
        endcase
        return sel;
    endfunction

    function automatic logic [7:0] sel_period(input logic [3:0] sel);
        logic [7:0] p;
        case (sel)
            4'd1:    p = 8'd50;
            4'd2:    p = 8'd75;
            4'd3:    p = 8'd100;
            4'd4:    p = 8'd125;
            4'd5:    p = 8'd150;
            4'd6:    p = 8'd175;
            4'd7:    p = 8'd200;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    // Gap must be a multiple of 25 no larger than 150
    function automatic logic gap_ok(input logic [7:0] gap);
        logic ok;
        case (gap)
            8'd0, 8'd25, 8'd50, 8'd75, 8'd100, 8'd125, 8'd150: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== hdl/fifteen_channel_firing_sequencer_top.sv =====
// Fifteen-channel firing sequencer: tick/start words in, channel drive words out.
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall     | i_in_word  (t_in_word)
//  out     | from block| o_out_valid / i_out_stall   | o_out_word (t_out_word)
//  cfg     | to block  | APB psel/penable/pwrite     | pwdata / prdata
//
// One word is taken per cycle unless o_in_stall is high; its result is registered
// in the output register or skid, on the same edge as the sequencing state.
// A two-entry output stage (output register plus skid) lets the input run while the output
// is stalled; o_in_stall rises only when both entries are full.
// Synchronous active-low reset: fire_time 50, test_mode 0, step count 1, all channels off.
module fifteen_channel_firing_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fcfs_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fcfs_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [7:0]       r_fire_time;
    logic [3:0]       r_test_mode;
    logic [3:0]       r_step;
    logic [3:0]       r_idx;
    fcfs_pkg::t_phase r_phase;
    logic [7:0]       r_tc;
    logic [7:0]       r_gap;
    logic [14:0]      r_latch;

    logic [3:0]       n_step;
    logic [3:0]       n_idx;
    fcfs_pkg::t_phase n_phase;
    logic [7:0]       n_tc;
    logic [7:0]       n_gap;
    logic [14:0]      n_latch;
    logic             n_done;

    fcfs_pkg::t_out_word r_out;
    fcfs_pkg::t_out_word r_skid;
    logic                r_out_vld;
    logic                r_skid_vld;
    fcfs_pkg::t_out_word res_word;

    logic in_acc;
    logic out_take;
    logic cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_acc   = i_in_valid && !r_skid_vld;
    assign out_take = r_out_vld && !i_out_stall;

    assign o_in_stall  = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire_time <= fcfs_pkg::FIRE_TIME_RST;
            r_test_mode <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                fcfs_pkg::REG_FIRE_TIME: r_fire_time <= pwdata[7:0];
                fcfs_pkg::REG_TEST_MODE: r_test_mode <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fcfs_pkg::REG_FIRE_TIME: prdata = {24'd0, r_fire_time};
            fcfs_pkg::REG_TEST_MODE: prdata = {28'd0, r_test_mode};
        endcase
    end

    // Next state: start handling, tick countdown, then pass zero-length phases.
    // At most three phase changes can chain in one word; a zero fire time with a zero
    // gap ends the rest of the sequence at once.
    always_comb begin : next_state
        logic [3:0] sel;
        logic       run_settle;
        n_step     = r_step;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_tc       = r_tc;
        n_gap      = r_gap;
        n_latch    = r_latch;
        n_done     = 1'b0;
        run_settle = 1'b0;
        sel = (r_test_mode != 4'd0) ? r_test_mode : fcfs_pkg::pins_to_sel(i_in_word.mode_pins);
        if (i_in_word.command) begin
            if (sel >= fcfs_pkg::SEL_FIRST && sel <= fcfs_pkg::SEL_MANUAL) begin
                n_phase = fcfs_pkg::PH_IDLE;
                n_idx   = '0;
                n_tc    = '0;
                n_latch = '0;
                if (sel == fcfs_pkg::SEL_MANUAL) begin
                    if (r_step >= fcfs_pkg::CH_LAST_STEP) begin
                        n_step  = '0;
                        n_latch = fcfs_pkg::one_hot(fcfs_pkg::CH_TOP);
                    end else begin
                        n_step  = r_step + 4'd1;
                        n_latch = fcfs_pkg::one_hot(r_step + 4'd1);
                    end
                end else begin
                    n_step = '0;
                    n_gap  = fcfs_pkg::sel_period(sel) - r_fire_time;
                    if (fcfs_pkg::gap_ok(n_gap)) begin
                        n_latch    = fcfs_pkg::one_hot(fcfs_pkg::CH_FIRST);
                        n_phase    = fcfs_pkg::PH_FIRE;
                        n_tc       = r_fire_time;
                        run_settle = 1'b1;
                    end
                end
            end
        end else if (r_phase == fcfs_pkg::PH_FIRE || r_phase == fcfs_pkg::PH_GAP) begin
            if (n_tc != 8'd0) begin
                n_tc = n_tc - 8'd1;
            end
            run_settle = 1'b1;
        end
        if (run_settle) begin
            for (int k = 0; k < 3; k++) begin
                if (n_phase == fcfs_pkg::PH_FIRE && n_tc == 8'd0) begin
                    n_latch = '0;
                    n_phase = fcfs_pkg::PH_GAP;
                    n_tc    = n_gap;
                end else if (n_phase == fcfs_pkg::PH_GAP && n_tc == 8'd0) begin
                    if (n_idx >= 4'(fcfs_pkg::CHANNELS - 1)) begin
                        n_phase = fcfs_pkg::PH_IDLE;
                        n_idx   = '0;
                        n_done  = 1'b1;
                    end else if (r_fire_time == 8'd0 && n_gap == 8'd0) begin
                        // every remaining channel passes with no tick spent
                        n_latch = '0;
                        n_phase = fcfs_pkg::PH_IDLE;
                        n_idx   = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_idx   = n_idx + 4'd1;
                        n_latch = fcfs_pkg::one_hot(n_idx + 4'd1);
                        n_phase = fcfs_pkg::PH_FIRE;
                        n_tc    = r_fire_time;
                    end
                end
            end
        end
    end

    // Result word from the next state
    always_comb begin : outputs
        res_word.channel_drive = n_latch;
        res_word.busy_res      = (n_phase == fcfs_pkg::PH_FIRE) ||
                                 (n_phase == fcfs_pkg::PH_GAP);
        res_word.sequence_done = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= fcfs_pkg::STEP_RST;
            r_idx   <= '0;
            r_phase <= fcfs_pkg::PH_IDLE;
            r_tc    <= '0;
            r_gap   <= '0;
            r_latch <= '0;
        end else if (in_acc) begin
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_gap   <= n_gap;
            r_latch <= n_latch;
        end
    end

    // Output register and skid: drain skid first, park the new word there if output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld && out_take) begin
            r_skid_vld <= 1'b0;
        end else if (in_acc) begin
            if (!r_out_vld || out_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld && out_take) begin
            r_out <= r_skid;
        end else if (in_acc) begin
            if (!r_out_vld || out_take) begin
                r_out <= res_word;
            end else begin
                r_skid <= res_word;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without an output word");

    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot0(r_out.channel_drive))
        else $error("more than one channel driven");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.sequence_done) |-> !r_out.busy_res)
        else $error("sequence done while still busy");

    a_active_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fcfs_pkg::PH_FIRE || r_phase == fcfs_pkg::PH_GAP) |-> (r_tc != 8'd0))
        else $error("active phase left with zero ticks");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fcfs_pkg::PH_IDLE) |-> (r_tc == 8'd0 && r_idx == 4'd0))
        else $error("idle phase with stale counters");

endmodule

// ===== verif/tb_fifteen_channel_firing_sequencer_top.sv =====
// Self-checking testbench for the fifteen-channel firing sequencer: predicts each output word.
`timescale 1ns / 100ps

module tb_fifteen_channel_firing_sequencer_top;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int   END_WAIT  = 5;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    fcfs_pkg::t_in_word            i_in_word = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    fcfs_pkg::t_out_word           o_out_word;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [fcfs_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // Sequencer image kept in step with the block
    logic [7:0]       m_fire_time;
    logic [3:0]       m_test_mode;
    logic [3:0]       seq_step;
    logic [3:0]       seq_chan;
    fcfs_pkg::t_phase seq_phase;
    logic [7:0]       seq_ticks;
    logic [7:0]       seq_gap;
    logic [14:0]      seq_drive;

    fcfs_pkg::t_out_word expected_words[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_cnt = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_done_seen = 0;
    int n_cfg_writes = 0;

    fifteen_channel_firing_sequencer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [14:0] channel_bit(input int ch);
        if (ch < 1 || ch > fcfs_pkg::CHANNELS) begin
            return '0;
        end
        return 15'(1) << (ch - 1);
    endfunction

    function automatic logic [3:0] pins_select(input logic [2:0] pins);
        case (pins)
            3'b000:  return 4'd1;
            3'b011:  return 4'd2;
            3'b001:  return 4'd3;
            3'b110:  return 4'd4;
            3'b100:  return 4'd5;
            3'b010:  return 4'd6;
            3'b101:  return 4'd7;
            default: return fcfs_pkg::SEL_MANUAL;
        endcase
    endfunction

    function automatic logic [7:0] period_ms(input logic [3:0] sel);
        case (sel)
            4'd1:    return 8'd50;
            4'd2:    return 8'd75;
            4'd3:    return 8'd100;
            4'd4:    return 8'd125;
            4'd5:    return 8'd150;
            4'd6:    return 8'd175;
            4'd7:    return 8'd200;
            default: return 8'd0;
        endcase
    endfunction

    // Walk through every phase whose count has run out; zero-length phases cost no tick
    function automatic logic advance_expired_phases();
        int guard;
        for (guard = 0; guard < 64; guard++) begin
            if (seq_phase == fcfs_pkg::PH_FIRE && seq_ticks == 8'd0) begin
                seq_drive = '0;
                seq_phase = fcfs_pkg::PH_GAP;
                seq_ticks = seq_gap;
            end else if (seq_phase == fcfs_pkg::PH_GAP && seq_ticks == 8'd0) begin
                if (int'(seq_chan) + 1 >= fcfs_pkg::CHANNELS) begin
                    seq_phase = fcfs_pkg::PH_IDLE;
                    seq_chan = '0;
                    return 1'b1;
                end
                seq_chan = seq_chan + 4'd1;
                seq_drive = channel_bit(int'(seq_chan) + 1);
                seq_phase = fcfs_pkg::PH_FIRE;
                seq_ticks = m_fire_time;
            end else begin
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic fcfs_pkg::t_out_word predict_firing(input fcfs_pkg::t_in_word w);
        fcfs_pkg::t_out_word r;
        logic                done;
        logic [3:0]          sel;
        int                  n;
        done = 1'b0;
        if (w.command == CMD_START) begin
            sel = (m_test_mode != 4'd0) ? m_test_mode : pins_select(w.mode_pins);
            // selections above manual leave everything as it was
            if (sel >= fcfs_pkg::SEL_FIRST && sel <= fcfs_pkg::SEL_MANUAL) begin
                seq_phase = fcfs_pkg::PH_IDLE;
                seq_chan = '0;
                seq_ticks = '0;
                seq_drive = '0;
                if (sel == fcfs_pkg::SEL_MANUAL) begin
                    n = int'(seq_step) + 1;
                    if (n >= int'(fcfs_pkg::CH_TOP)) begin
                        seq_step = '0;
                        seq_drive = channel_bit(int'(fcfs_pkg::CH_TOP));
                    end else begin
                        seq_step = 4'(n);
                        seq_drive = channel_bit(n);
                    end
                end else begin
                    seq_step = '0;
                    seq_gap = period_ms(sel) - m_fire_time;
                    if (seq_gap <= 8'd150 && (seq_gap % 8'd25) == 8'd0) begin
                        seq_drive = channel_bit(1);
                        seq_phase = fcfs_pkg::PH_FIRE;
                        seq_ticks = m_fire_time;
                        done = advance_expired_phases();
                    end
                end
            end
        end else if (seq_phase == fcfs_pkg::PH_FIRE || seq_phase == fcfs_pkg::PH_GAP) begin
            if (seq_ticks != 8'd0) begin
                seq_ticks = seq_ticks - 8'd1;
            end
            done = advance_expired_phases();
        end
        r.channel_drive = seq_drive;
        r.busy_res = (seq_phase == fcfs_pkg::PH_FIRE || seq_phase == fcfs_pkg::PH_GAP);
        r.sequence_done = done;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        fcfs_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word %h", o_out_word);
                err_cnt++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.channel_drive !== exp_w.channel_drive) begin
                    $error("channel_drive: expected %h, got %h",
                           exp_w.channel_drive, o_out_word.channel_drive);
                    err_cnt++;
                end
                if (o_out_word.busy_res !== exp_w.busy_res) begin
                    $error("busy_res: expected %b, got %b", exp_w.busy_res, o_out_word.busy_res);
                    err_cnt++;
                end
                if (o_out_word.sequence_done !== exp_w.sequence_done) begin
                    $error("sequence_done: expected %b, got %b",
                           exp_w.sequence_done, o_out_word.sequence_done);
                    err_cnt++;
                end
                if (exp_w.sequence_done) begin
                    n_done_seen++;
                end
                n_checked++;
            end
        end
    end

    // Hold the word until taken; valid stays up for a back-to-back word
    task automatic send_word(input logic cmd, input logic [2:0] pins);
        fcfs_pkg::t_in_word w;
        w.command = cmd;
        w.mode_pins = pins;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        expected_words.push_back(predict_firing(w));
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == fcfs_pkg::REG_FIRE_TIME) begin
            m_fire_time = data[7:0];
        end else begin
            m_test_mode = data[3:0];
        end
        n_cfg_writes++;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(CMD_TICK, 3'b000);     // idle tick: nothing moves
        send_word(CMD_START, 3'b111);    // manual from reset step
        send_word(CMD_TICK, 3'b111);     // latch holds across idle ticks
        send_word(CMD_START, 3'b000);    // 50 ms, zero gap
        send_word(CMD_TICK, 3'b000);
        send_word(CMD_TICK, 3'b010);
        send_word(CMD_START, 3'b111);    // restart while running
        send_word(CMD_START, 3'b011);
        send_word(CMD_START, 3'b001);
        send_word(CMD_START, 3'b110);
        send_word(CMD_START, 3'b100);
        send_word(CMD_START, 3'b010);
        send_word(CMD_START, 3'b101);
        drain();
        cfg_write(fcfs_pkg::REG_FIRE_TIME, 32'd0);
        send_word(CMD_START, 3'b101);    // gap of 200 is rejected
        send_word(CMD_START, 3'b000);    // zero-length fire phase
        send_word(CMD_TICK, 3'b000);
        drain();
        cfg_write(fcfs_pkg::REG_FIRE_TIME, 32'd255);
        send_word(CMD_START, 3'b000);    // wrapped gap outside the set
        send_word(CMD_TICK, 3'b000);
        drain();
        cfg_write(fcfs_pkg::REG_FIRE_TIME, 32'(fcfs_pkg::FIRE_TIME_RST));
        send_word(CMD_START, 3'b000);
        drain();
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'd15);
        send_word(CMD_START, 3'b011);    // no mode selected: running sequence survives
        send_word(CMD_TICK, 3'b000);
        drain();
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'(fcfs_pkg::SEL_FIRST));
        send_word(CMD_START, 3'b111);    // forced period beats manual pins
        send_word(CMD_TICK, 3'b111);
        drain();
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'd0);
    endtask

    task automatic test_manual_wrap();
        int i;
        drain();
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'(fcfs_pkg::SEL_MANUAL));
        for (i = 0; i < 17; i++) begin
            send_word(CMD_START, 3'($urandom));
        end
        send_word(CMD_TICK, 3'($urandom));
        drain();
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'd0);
    endtask

    // Forced 50 ms period: every channel costs fire + gap = 50 ticks
    task automatic test_full_sequence(input logic [7:0] fire);
        int i;
        drain();
        cfg_write(fcfs_pkg::REG_FIRE_TIME, 32'(fire));
        cfg_write(fcfs_pkg::REG_TEST_MODE, 32'(fcfs_pkg::SEL_FIRST));
        send_word(CMD_START, 3'($urandom));
        for (i = 0; i < fcfs_pkg::CHANNELS * 50 + 3; i++) begin
            send_word(CMD_TICK, 3'($urandom));
        end
        drain();
    endtask

    task automatic test_random(input int chunks);
        int         c;
        int         i;
        logic [3:0] s;
        logic [7:0] ft;
        logic [3:0] tm;
        for (c = 0; c < chunks; c++) begin
            drain();
            s = 4'($urandom_range(7, 1));
            case ($urandom_range(3))
                0, 1:    ft = period_ms(s) - 8'(25 * $urandom_range(6));
                2:       ft = 8'($urandom_range(255));
                default: ft = $urandom_range(1) ? 8'hFF : 8'h00;
            endcase
            case ($urandom_range(3))
                0:       tm = s;
                1:       tm = 4'($urandom_range(15));
                default: tm = 4'd0;
            endcase
            cfg_write(fcfs_pkg::REG_FIRE_TIME, 32'(ft));
            cfg_write(fcfs_pkg::REG_TEST_MODE, 32'(tm));
            for (i = 0; i < 100; i++) begin
                if ($urandom_range(99) < 2) begin
                    send_word(CMD_START, 3'($urandom));
                end else begin
                    send_word(CMD_TICK, 3'($urandom));
                end
            end
        end
    endtask

    initial begin
        m_fire_time = fcfs_pkg::FIRE_TIME_RST;
        m_test_mode = '0;
        seq_step = fcfs_pkg::STEP_RST;
        seq_chan = '0;
        seq_phase = fcfs_pkg::PH_IDLE;
        seq_ticks = '0;
        seq_gap = '0;
        seq_drive = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 14;
        recv_stall_pct = 50;
        test_directed();
        test_manual_wrap();
        test_random(2);

        send_idle_pct = 50;
        recv_stall_pct = 14;
        test_full_sequence(8'd50);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(4);

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            err_cnt++;
        end
        $display("Sent %0d tick/start words and checked %0d results, %0d full sequences,",
                 n_sent, n_checked, n_done_seen);
        $display("over %0d register writes and three idle/stall mixes.", n_cfg_writes);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
